// File: hw/rtl/psd_pkg.sv
// shared constants for the point to segment distance block
// no dependencies
package psd_pkg;

	// width of the result word
	localparam int OUT_W = 17;

endpackage

// File: hw/rtl/psd_if.sv
// valid/ready channel interfaces for the point to segment distance block
// depends on psd_pkg
interface psd_in_if #(
	parameter int COORD_BITS = 16
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] ax;
	logic signed [COORD_BITS-1:0] ay;
	logic signed [COORD_BITS-1:0] az;
	logic signed [COORD_BITS-1:0] bx;
	logic signed [COORD_BITS-1:0] by_coord;
	logic signed [COORD_BITS-1:0] bz;
	logic signed [COORD_BITS-1:0] px;
	logic signed [COORD_BITS-1:0] py;
	logic signed [COORD_BITS-1:0] pz;

	modport source (output valid, ax, ay, az, bx, by_coord, bz, px, py, pz, input ready);
	modport sink (input valid, ax, ay, az, bx, by_coord, bz, px, py, pz, output ready);
endinterface

interface psd_out_if;
	logic                       valid;
	logic                       ready;
	logic [psd_pkg::OUT_W-1:0] ceil_distance;

	modport source (output valid, ceil_distance, input ready);
	modport sink (input valid, ceil_distance, output ready);
endinterface

// File: hw/rtl/psd_front.sv
// front end: differences, products, case selection, numerator and denominator
// depends on psd_pkg and psd_in_if
module psd_front #(
	parameter int COORD_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	psd_in_if.sink                      in_ch,
	output logic                        valid,
	output logic [4*COORD_BITS+3:0]     num,
	output logic [2*COORD_BITS+1:0]     den,
	output logic                        nz
);
	import psd_pkg::*;

	localparam int DIW = COORD_BITS + 1;
	localparam int PW  = 2*COORD_BITS + 2;
	localparam int DW  = 2*COORD_BITS + 2;
	localparam int WDW = 2*COORD_BITS + 3;
	localparam int RW  = 4*COORD_BITS + 4;

	logic [4:0] v_q;

	// stage 1: vector differences
	logic signed [DIW-1:0] dx_s1, dy_s1, dz_s1, wx_s1, wy_s1, wz_s1, ex_s1, ey_s1, ez_s1;
	// stage 2: products
	logic signed [PW-1:0] dxx_s2, dyy_s2, dzz_s2, wxx_s2, wyy_s2, wzz_s2;
	logic signed [PW-1:0] exx_s2, eyy_s2, ezz_s2, wxdx_s2, wydy_s2, wzdz_s2;
	logic signed [PW-1:0] wydz_s2, wzdy_s2, wzdx_s2, wxdz_s2, wxdy_s2, wydx_s2;
	// stage 3: sums
	logic [DW-1:0]         dd_s3, ww_s3, ee_s3;
	logic signed [WDW-1:0] wd_s3;
	logic signed [PW-1:0]  cx_s3, cy_s3, cz_s3;
	// stage 4: cross product squares and case flags
	logic signed [RW-1:0] cxx_s4, cyy_s4, czz_s4;
	logic [DW-1:0]        dd_s4, ww_s4, ee_s4;
	logic                 sel_a_s4, sel_b_s4;
	// stage 5
	logic [RW-1:0] num_s5;
	logic [DW-1:0] den_s5;
	logic          nz_s5;
	logic [RW-1:0] num_d;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[3:0], in_ch.valid};
		end
	end

	// differences
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1 <= DIW'(in_ch.bx) - DIW'(in_ch.ax);
			dy_s1 <= DIW'(in_ch.by_coord) - DIW'(in_ch.ay);
			dz_s1 <= DIW'(in_ch.bz) - DIW'(in_ch.az);
			wx_s1 <= DIW'(in_ch.px) - DIW'(in_ch.ax);
			wy_s1 <= DIW'(in_ch.py) - DIW'(in_ch.ay);
			wz_s1 <= DIW'(in_ch.pz) - DIW'(in_ch.az);
			ex_s1 <= DIW'(in_ch.px) - DIW'(in_ch.bx);
			ey_s1 <= DIW'(in_ch.py) - DIW'(in_ch.by_coord);
			ez_s1 <= DIW'(in_ch.pz) - DIW'(in_ch.bz);
		end
	end

	// narrow products
	always_ff @(posedge clk) begin
		if (adv) begin
			dxx_s2  <= dx_s1 * dx_s1;
			dyy_s2  <= dy_s1 * dy_s1;
			dzz_s2  <= dz_s1 * dz_s1;
			wxx_s2  <= wx_s1 * wx_s1;
			wyy_s2  <= wy_s1 * wy_s1;
			wzz_s2  <= wz_s1 * wz_s1;
			exx_s2  <= ex_s1 * ex_s1;
			eyy_s2  <= ey_s1 * ey_s1;
			ezz_s2  <= ez_s1 * ez_s1;
			wxdx_s2 <= wx_s1 * dx_s1;
			wydy_s2 <= wy_s1 * dy_s1;
			wzdz_s2 <= wz_s1 * dz_s1;
			wydz_s2 <= wy_s1 * dz_s1;
			wzdy_s2 <= wz_s1 * dy_s1;
			wzdx_s2 <= wz_s1 * dx_s1;
			wxdz_s2 <= wx_s1 * dz_s1;
			wxdy_s2 <= wx_s1 * dy_s1;
			wydx_s2 <= wy_s1 * dx_s1;
		end
	end

	// dot products, squared lengths and cross product
	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s3 <= DW'(dxx_s2 + dyy_s2 + dzz_s2);
			ww_s3 <= DW'(wxx_s2 + wyy_s2 + wzz_s2);
			ee_s3 <= DW'(exx_s2 + eyy_s2 + ezz_s2);
			wd_s3 <= WDW'(wxdx_s2) + WDW'(wydy_s2) + WDW'(wzdz_s2);
			cx_s3 <= wydz_s2 - wzdy_s2;
			cy_s3 <= wzdx_s2 - wxdz_s2;
			cz_s3 <= wxdy_s2 - wydx_s2;
		end
	end

	// cross squares and where the foot of the projection lies
	always_ff @(posedge clk) begin
		if (adv) begin
			cxx_s4   <= RW'(cx_s3) * RW'(cx_s3);
			cyy_s4   <= RW'(cy_s3) * RW'(cy_s3);
			czz_s4   <= RW'(cz_s3) * RW'(cz_s3);
			dd_s4    <= dd_s3;
			ww_s4    <= ww_s3;
			ee_s4    <= ee_s3;
			sel_a_s4 <= (dd_s3 == '0) || (wd_s3 <= 0);
			sel_b_s4 <= wd_s3 >= signed'({1'b0, dd_s3});
		end
	end

	// numerator and denominator for the root
	always_comb begin
		if (sel_a_s4) begin
			num_d = RW'(ww_s4);
		end else if (sel_b_s4) begin
			num_d = RW'(ee_s4);
		end else begin
			num_d = RW'(cxx_s4 + cyy_s4 + czz_s4);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s5 <= num_d;
			den_s5 <= (sel_a_s4 || sel_b_s4) ? DW'(1) : dd_s4;
			nz_s5  <= num_d != '0;
		end
	end

	assign valid = v_q[4];
	assign num   = num_s5;
	assign den   = den_s5;
	assign nz    = nz_s5;
endmodule

// File: hw/rtl/psd_root_stage.sv
// one bit of q, the largest integer with q^2 den < num, restoring form
// no dependencies beyond its parameters
module psd_root_stage #(
	parameter int RW = 68,
	parameter int DW = 34,
	parameter int TW = 51,
	parameter int QW = 17,
	parameter int K  = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          v_in,
	input  logic [RW-1:0] rem_in,
	input  logic [DW-1:0] den_in,
	input  logic [TW-1:0] t_in,
	input  logic [QW-1:0] q_in,
	input  logic          nz_in,
	output logic          v_out,
	output logic [RW-1:0] rem_out,
	output logic [DW-1:0] den_out,
	output logic [TW-1:0] t_out,
	output logic [QW-1:0] q_out,
	output logic          nz_out
);
	localparam int AW = RW + 1;

	logic [AW-1:0] cand;
	logic          take;

	// (q + 2^k)^2 den - q^2 den = (q den) 2^(k+1) + den 4^k
	assign cand = (AW'(t_in) << (K + 1)) + (AW'(den_in) << (2 * K));
	assign take = cand < AW'(rem_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (adv) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_out <= take ? rem_in - cand[RW-1:0] : rem_in;
			t_out   <= take ? t_in + (TW'(den_in) << K) : t_in;
			q_out   <= take ? (q_in | (QW'(1) << K)) : q_in;
			den_out <= den_in;
			nz_out  <= nz_in;
		end
	end
endmodule

// File: hw/rtl/point_segment_distance_3d_core.sv
// top level of the point to segment distance block
// depends on psd_pkg, psd_if, psd_front and psd_root_stage
//
// usage:
//   in_ch carries one word per query: segment ends A, B and point P, each
//   coordinate COORD_BITS wide, two's complement. out_ch returns one word per
//   query: ceil_distance, the smallest integer not below the distance from P
//   to the closed segment AB, in query order.
//   from acceptance a word passes five arithmetic stages, one pipeline
//   stage per root bit and an output register; a new word is accepted every
//   cycle unless a stalled receiver holds the pipeline.
//   all stages move together: in_ch.ready is high whenever the output register
//   is empty or being taken, so a stalled receiver holds the whole pipeline
//   and nothing is lost or repeated.
//   reset clears every valid bit; the block is ready straight after reset.
module point_segment_distance_3d_core #(
	parameter int COORD_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	psd_in_if.sink    in_ch,
	psd_out_if.source out_ch
);
	import psd_pkg::*;

	localparam int QW = COORD_BITS + 1;
	localparam int DW = 2*COORD_BITS + 2;
	localparam int RW = 4*COORD_BITS + 4;
	localparam int TW = DW + QW;

	logic adv;
	logic f_valid, f_nz;
	logic [RW-1:0] f_num;
	logic [DW-1:0] f_den;

	logic          v_c   [0:QW];
	logic [RW-1:0] rem_c [0:QW];
	logic [DW-1:0] den_c [0:QW];
	logic [TW-1:0] t_c   [0:QW];
	logic [QW-1:0] q_c   [0:QW];
	logic          nz_c  [0:QW];

	logic             out_v_q;
	logic [OUT_W-1:0] out_d_q;
	logic [QW:0]      root;

	// whole pipeline moves when the output register is empty or being taken
	assign adv         = !out_v_q || out_ch.ready;
	assign in_ch.ready = adv;

	psd_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.in_ch  (in_ch),
		.valid  (f_valid),
		.num    (f_num),
		.den    (f_den),
		.nz     (f_nz)
	);

	assign v_c[0]   = f_valid;
	assign rem_c[0] = f_num;
	assign den_c[0] = f_den;
	assign t_c[0]   = '0;
	assign q_c[0]   = '0;
	assign nz_c[0]  = f_nz;

	// one root bit per stage, most significant first
	for (genvar i = 0; i < QW; i++) begin : g_root
		psd_root_stage #(
			.RW (RW),
			.DW (DW),
			.TW (TW),
			.QW (QW),
			.K  (QW - 1 - i)
		) u_stage (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.v_in    (v_c[i]),
			.rem_in  (rem_c[i]),
			.den_in  (den_c[i]),
			.t_in    (t_c[i]),
			.q_in    (q_c[i]),
			.nz_in   (nz_c[i]),
			.v_out   (v_c[i+1]),
			.rem_out (rem_c[i+1]),
			.den_out (den_c[i+1]),
			.t_out   (t_c[i+1]),
			.q_out   (q_c[i+1]),
			.nz_out  (nz_c[i+1])
		);
	end

	// largest q with q^2 den < num, so the ceiling is q + 1 unless num is zero
	assign root = nz_c[QW] ? (QW+1)'(q_c[QW]) + (QW+1)'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_c[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_d_q <= OUT_W'(root);
		end
	end

	assign out_ch.valid         = out_v_q;
	assign out_ch.ceil_distance = out_d_q;
endmodule

// File: hw/rtl/psd_checker.sv
// port level checks for the point to segment distance block
// depends on psd_pkg; bound to point_segment_distance_3d_core
module psd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [psd_pkg::OUT_W-1:0] out_data
);
	import psd_pkg::*;

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped during stall");

	// a stalled result word keeps its value
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("result word changed during stall");

	// input side is held exactly while the output is stalled
	a_ready_link: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output stall");

	// a new result only appears after the pipeline has moved
	a_rise_moved: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared while pipeline was held");
endmodule

bind point_segment_distance_3d_core psd_checker u_psd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_data  (out_ch.ceil_distance)
);
